[design/jfp_pkg.sv]
// jfp_pkg: shared widths, reset values and register codes of the jacobi stencil sweep
// no dependencies; used by the output and configuration interfaces and the top level
package jfp_pkg;

    // configuration register widths
    localparam int GRID_W     = 11;
    localparam int TOL_W      = 36;
    localparam int ITER_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 36;

    // register values after reset
    localparam logic [GRID_W-1:0] GRID_RST = 11'd1024;
    localparam logic [TOL_W-1:0]  TOL_RST  = 36'd687195;
    localparam logic [ITER_W-1:0] ITER_RST = 12'd3000;

    // saturation value of the per-sweep change sum
    localparam logic [TOL_W-1:0] SUM_SAT = {TOL_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE  = 2'd0,
        CFG_TOL_SUM    = 2'd1,
        CFG_ITER_LIMIT = 2'd2
    } t_cfg_idx;

endpackage

[design/jfp_in_if.sv]
// jfp_in_if: input cell channel, valid/ready with one cell value per transaction
// no dependencies
interface jfp_in_if #(
    parameter int VALUE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

[design/jfp_out_if.sv]
// jfp_out_if: result channel, valid/ready with cell update or sweep summary fields
// depends on jfp_pkg for the summary field widths
interface jfp_out_if #(
    parameter int VALUE_BITS = 16,
    parameter int COORD_W    = 11
) ();
    logic                      valid;
    logic                      ready;
    logic [VALUE_BITS-1:0]     new_value;
    logic [COORD_W-1:0]        cell_row;
    logic [COORD_W-1:0]        cell_col;
    logic [VALUE_BITS-1:0]     abs_change;
    logic                      sweep_end;
    logic [jfp_pkg::TOL_W-1:0] sweep_change_sum;
    logic [jfp_pkg::ITER_W-1:0] sweep_number;
    logic                      converged_or_limit;

    modport source (
        output valid, output new_value, output cell_row, output cell_col,
        output abs_change, output sweep_end, output sweep_change_sum,
        output sweep_number, output converged_or_limit, input ready
    );
    modport sink (
        input valid, input new_value, input cell_row, input cell_col,
        input abs_change, input sweep_end, input sweep_change_sum,
        input sweep_number, input converged_or_limit, output ready
    );
endinterface

[design/jfp_cfg_if.sv]
// jfp_cfg_if: configuration write channel, valid/ready with register index and data
// depends on jfp_pkg for index and data widths
interface jfp_cfg_if ();
    logic                          valid;
    logic                          ready;
    logic [jfp_pkg::CFG_IDX_W-1:0] index;
    logic [jfp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/jacobi_five_point_stencil_sweep.sv]
// jacobi_five_point_stencil_sweep: streamed five-point relaxation over a bordered grid
// throughput: one cell per cycle unless a stall at o_res.ready backs up the stages;
// each line store is read once and written once a cycle
// reset (synchronous, active low): counters, change sum, sweep count and valids cleared,
// registers to their defaults; the line stores are not cleared, every entry read in a
// sweep is written earlier in that sweep
// depends on jfp_pkg, jfp_in_if, jfp_out_if, jfp_cfg_if
module jacobi_five_point_stencil_sweep #(
    parameter int MAX_GRID   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jfp_in_if.sink     i_cell,
    jfp_out_if.source  o_res,
    jfp_cfg_if.sink    i_cfg
);

    localparam int DEPTH = MAX_GRID + 2;
    localparam int CW    = $clog2(MAX_GRID + 2);
    localparam int VB    = VALUE_BITS;
    localparam int SW    = VALUE_BITS + 3;
    localparam int PW    = 2 * SW;
    localparam logic [SW-1:0] RECIP = SW'((64'd1 << SW) / 64'd5);

    // configuration registers
    logic [jfp_pkg::GRID_W-1:0] r_grid_size;
    logic [jfp_pkg::TOL_W-1:0]  r_tol;
    logic [jfp_pkg::ITER_W-1:0] r_iter_limit;

    // raster position and sweep state
    logic [CW-1:0]              r_row, r_col, n_row, n_col;
    logic [jfp_pkg::TOL_W-1:0]  r_acc;
    logic [jfp_pkg::ITER_W-1:0] r_sweep;

    // line stores, one per row parity
    logic [VB-1:0] r_mem_even [DEPTH];
    logic [VB-1:0] r_mem_odd  [DEPTH];
    logic [VB-1:0] r_rd_even, r_rd_odd;
    logic [CW-1:0] ra_even, ra_odd, right_addr;

    // pipeline stages
    logic          r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;
    logic          s_en1, s_en2, s_en3, s_en4, s_en5, s_en_out;
    logic          r_s1_comp, r_s1_last, r_s1_first, r_s1_par;
    logic [CW-1:0] r_s1_row, r_s1_col;
    logic [VB-1:0] r_s1_value;
    logic [VB-1:0] r_left, r_centre;
    logic          r_s2_comp, r_s2_last;
    logic [CW-1:0] r_s2_row, r_s2_col;
    logic [SW-1:0] r_s2_x;
    logic [VB-1:0] r_s2_centre;
    logic          r_s3_comp, r_s3_last;
    logic [CW-1:0] r_s3_row, r_s3_col;
    logic [SW-1:0] r_s3_x;
    logic [VB-1:0] r_s3_q0, r_s3_centre;
    logic          r_s4_comp, r_s4_last;
    logic [CW-1:0] r_s4_row, r_s4_col;
    logic [VB-1:0] r_s4_nv, r_s4_centre;
    logic          r_s5_comp, r_s5_last;
    logic [CW-1:0] r_s5_row, r_s5_col;
    logic [VB-1:0] r_s5_nv, r_s5_d;

    // output register
    logic [VB-1:0]              r_o_new, r_o_abs;
    logic [CW-1:0]              r_o_row, r_o_col;
    logic                       r_o_end, r_o_done;
    logic [jfp_pkg::TOL_W-1:0]  r_o_sum;
    logic [jfp_pkg::ITER_W-1:0] r_o_num;

    // combinational helpers
    logic                       s_in_acc, s_cfg_acc, s_grid_wr;
    logic [CW-1:0]              eff_n, last_idx, in_row_out;
    logic                       in_border, in_comp, in_last;
    logic [VB-1:0]              in_value, s1_up, s1_right;
    logic [SW-1:0]              s1_x, s3_five_q, s3_rem;
    logic [PW-1:0]              s2_prod;
    logic [VB-1:0]              s3_nv, s4_d;
    logic [jfp_pkg::TOL_W:0]    s5_acc_sum;
    logic [jfp_pkg::TOL_W-1:0]  s5_acc_sat;
    logic [jfp_pkg::ITER_W-1:0] s5_num;
    logic                       s5_done;

    assign s_in_acc  = i_cell.valid && i_cell.ready;
    assign s_cfg_acc = i_cfg.valid && i_cfg.ready;
    assign s_grid_wr = s_cfg_acc
                       && (jfp_pkg::t_cfg_idx'(i_cfg.index) == jfp_pkg::CFG_GRID_SIZE);
    assign i_cfg.ready = 1'b1;

    // stage enables, a stage moves when empty or when the next one moves
    assign s_en_out = !r_vo || o_res.ready;
    assign s_en5    = !r_v5 || s_en_out;
    assign s_en4    = !r_v4 || s_en5;
    assign s_en3    = !r_v3 || s_en4;
    assign s_en2    = !r_v2 || s_en3;
    assign s_en1    = !r_v1 || s_en2;
    assign i_cell.ready = s_en1;

    // effective grid size, clamped to 1..MAX_GRID
    always_comb begin
        if (r_grid_size == '0) begin
            eff_n = CW'(1);
        end else if (int'(r_grid_size) > MAX_GRID) begin
            eff_n = CW'(MAX_GRID);
        end else begin
            eff_n = CW'(r_grid_size);
        end
        last_idx = eff_n + CW'(1);
    end

    // classify the incoming cell and step the raster position
    always_comb begin
        in_border  = (r_row == '0) || (r_row == last_idx)
                     || (r_col == '0) || (r_col == last_idx);
        in_value   = in_border ? '0 : i_cell.cell_value;
        in_comp    = (r_row >= CW'(2)) && (r_col != '0) && (r_col < last_idx);
        in_last    = (r_row == last_idx) && (r_col == last_idx);
        in_row_out = in_last ? r_row : r_row - CW'(1);
        right_addr = (r_col == last_idx) ? '0 : r_col + CW'(1);
        if (in_last) begin
            n_row = '0;
            n_col = '0;
        end else if (r_col == last_idx) begin
            n_row = r_row + CW'(1);
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + CW'(1);
        end
        // row parity picks which store gives the cell above and which the right one
        ra_even = r_row[0] ? right_addr : r_col;
        ra_odd  = r_row[0] ? r_col : right_addr;
    end

    // even-row line store, read before write on the same entry
    always_ff @(posedge i_clk) begin
        if (s_en1) begin
            r_rd_even <= r_mem_even[ra_even];
        end
        if (s_in_acc && !r_row[0]) begin
            r_mem_even[r_col] <= in_value;
        end
    end

    // odd-row line store
    always_ff @(posedge i_clk) begin
        if (s_en1) begin
            r_rd_odd <= r_mem_odd[ra_odd];
        end
        if (s_in_acc && r_row[0]) begin
            r_mem_odd[r_col] <= in_value;
        end
    end

    // configuration registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size  <= jfp_pkg::GRID_RST;
            r_tol        <= jfp_pkg::TOL_RST;
            r_iter_limit <= jfp_pkg::ITER_RST;
            r_row        <= '0;
            r_col        <= '0;
        end else begin
            if (s_in_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (s_cfg_acc) begin
                case (jfp_pkg::t_cfg_idx'(i_cfg.index))
                    jfp_pkg::CFG_GRID_SIZE: begin
                        r_grid_size <= i_cfg.data[jfp_pkg::GRID_W-1:0];
                        r_row       <= '0;
                        r_col       <= '0;
                    end
                    jfp_pkg::CFG_TOL_SUM: begin
                        r_tol <= i_cfg.data[jfp_pkg::TOL_W-1:0];
                    end
                    jfp_pkg::CFG_ITER_LIMIT: begin
                        r_iter_limit <= i_cfg.data[jfp_pkg::ITER_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s_en1) r_v1 <= s_in_acc;
            if (s_en2) r_v2 <= r_v1;
            if (s_en3) r_v3 <= r_v2;
            if (s_en4) r_v4 <= r_v3;
            if (s_en5) r_v5 <= r_v4;
        end
    end

    // stage 1: cell attributes alongside the store reads
    always_ff @(posedge i_clk) begin
        if (s_en1) begin
            r_s1_comp  <= s_in_acc && in_comp;
            r_s1_last  <= s_in_acc && in_last;
            r_s1_first <= (r_col == '0);
            r_s1_par   <= r_row[0];
            r_s1_row   <= in_row_out;
            r_s1_col   <= r_col;
            r_s1_value <= in_value;
        end
    end

    // five-cell sum with the rounding offset
    always_comb begin
        s1_up    = r_s1_par ? r_rd_odd : r_rd_even;
        s1_right = r_s1_par ? r_rd_even : r_rd_odd;
        s1_x     = SW'(r_left) + SW'(r_centre) + SW'(s1_right) + SW'(s1_up)
                   + SW'(r_s1_value) + SW'(2);
    end

    // stage 2: sum register and the sliding window over the row above
    always_ff @(posedge i_clk) begin
        if (s_en2) begin
            r_s2_comp   <= r_v1 && r_s1_comp;
            r_s2_last   <= r_v1 && r_s1_last;
            r_s2_row    <= r_s1_row;
            r_s2_col    <= r_s1_col;
            r_s2_x      <= s1_x;
            r_s2_centre <= r_centre;
        end
        if (r_v1 && s_en2) begin
            r_left   <= r_s1_first ? '0 : r_centre;
            r_centre <= s1_right;
        end
    end

    // stage 3: quotient estimate by reciprocal multiply, at most one short
    assign s2_prod = PW'(r_s2_x) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (s_en3) begin
            r_s3_comp   <= r_s2_comp;
            r_s3_last   <= r_s2_last;
            r_s3_row    <= r_s2_row;
            r_s3_col    <= r_s2_col;
            r_s3_x      <= r_s2_x;
            r_s3_q0     <= s2_prod[SW+VB-1:SW];
            r_s3_centre <= r_s2_centre;
        end
    end

    // stage 4: remainder correction
    always_comb begin
        s3_five_q = SW'({r_s3_q0, 2'b00}) + SW'(r_s3_q0);
        s3_rem    = r_s3_x - s3_five_q;
        s3_nv     = r_s3_q0 + VB'(s3_rem >= SW'(5));
    end

    always_ff @(posedge i_clk) begin
        if (s_en4) begin
            r_s4_comp   <= r_s3_comp;
            r_s4_last   <= r_s3_last;
            r_s4_row    <= r_s3_row;
            r_s4_col    <= r_s3_col;
            r_s4_nv     <= s3_nv;
            r_s4_centre <= r_s3_centre;
        end
    end

    // stage 5: absolute change
    assign s4_d = (r_s4_nv > r_s4_centre) ? r_s4_nv - r_s4_centre : r_s4_centre - r_s4_nv;

    always_ff @(posedge i_clk) begin
        if (s_en5) begin
            r_s5_comp <= r_s4_comp;
            r_s5_last <= r_s4_last;
            r_s5_row  <= r_s4_row;
            r_s5_col  <= r_s4_col;
            r_s5_nv   <= r_s4_nv;
            r_s5_d    <= s4_d;
        end
    end

    // saturating change sum and end-of-sweep decision
    always_comb begin
        s5_acc_sum = {1'b0, r_acc} + (jfp_pkg::TOL_W + 1)'(r_s5_d);
        s5_acc_sat = s5_acc_sum[jfp_pkg::TOL_W] ? jfp_pkg::SUM_SAT
                                                : s5_acc_sum[jfp_pkg::TOL_W-1:0];
        s5_num     = r_sweep + jfp_pkg::ITER_W'(1);
        s5_done    = (r_acc < r_tol) || (s5_num >= r_iter_limit);
    end

    // output register, change sum and sweep count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo    <= 1'b0;
            r_acc   <= '0;
            r_sweep <= '0;
        end else begin
            if (s_en_out) begin
                r_vo <= r_v5 && (r_s5_comp || r_s5_last);
            end
            if (r_v5 && s_en_out && r_s5_comp) begin
                r_acc <= s5_acc_sat;
            end
            if (r_v5 && s_en_out && r_s5_last) begin
                r_acc   <= '0;
                r_sweep <= s5_done ? '0 : s5_num;
            end
            if (s_grid_wr) begin
                r_acc <= '0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_en_out) begin
            r_o_row <= r_s5_row;
            r_o_col <= r_s5_col;
            if (r_s5_last) begin
                r_o_new  <= '0;
                r_o_abs  <= '0;
                r_o_end  <= 1'b1;
                r_o_sum  <= r_acc;
                r_o_num  <= s5_num;
                r_o_done <= s5_done;
            end else begin
                r_o_new  <= r_s5_nv;
                r_o_abs  <= r_s5_d;
                r_o_end  <= 1'b0;
                r_o_sum  <= '0;
                r_o_num  <= '0;
                r_o_done <= 1'b0;
            end
        end
    end

    assign o_res.valid              = r_vo;
    assign o_res.new_value          = r_o_new;
    assign o_res.cell_row           = r_o_row;
    assign o_res.cell_col           = r_o_col;
    assign o_res.abs_change         = r_o_abs;
    assign o_res.sweep_end          = r_o_end;
    assign o_res.sweep_change_sum   = r_o_sum;
    assign o_res.sweep_number       = r_o_num;
    assign o_res.converged_or_limit = r_o_done;

    // raster position never leaves the bordered grid
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= last_idx) && (r_col <= last_idx))
        else $error("raster position outside bordered grid");

    // a summary transaction carries no cell update and sits on the corner
    a_summary_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_o_end |-> (r_o_new == '0) && (r_o_abs == '0) && (r_o_row == r_o_col))
        else $error("malformed sweep summary");

    // a cell transaction reports an interior cell with empty summary fields
    a_cell_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !r_o_end |-> (r_o_row != '0) && (r_o_col != '0) && (r_o_sum == '0)
                             && !r_o_done)
        else $error("malformed cell result");

    // an empty output register never holds back the input side
    a_intake_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vo |-> i_cell.ready)
        else $error("input stalled with empty output register");

endmodule
